>>> hw/rtl/bir_pkg.sv
// Shared types and constants for the bilinear image resampler.
// No dependencies.
package bir_pkg;

    localparam int DEF_MAX_WIDTH    = 256;
    localparam int DEF_MAX_HEIGHT   = 256;
    localparam int DEF_MAX_CHANNELS = 4;

    localparam int STORE_AW = 18;   // frame store byte address
    localparam int DATA_W   = 8;
    localparam int COORD_W  = 12;
    localparam int CH_W     = 2;
    localparam int SIZE_W   = 9;
    localparam int CHANS_W  = 3;
    localparam int SCALE_W  = 24;
    localparam int FRAC_W   = 16;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic [FRAC_W:0] FRAC_ONE = {1'b1, {FRAC_W{1'b0}}};

    localparam logic [SIZE_W-1:0]  RST_SRC_WIDTH  = 9'd256;
    localparam logic [SIZE_W-1:0]  RST_SRC_HEIGHT = 9'd256;
    localparam logic [CHANS_W-1:0] RST_CHANNELS   = 3'd3;
    localparam logic [SCALE_W-1:0] RST_SCALE      = 24'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH     = 3'd0,
        CFG_SRC_HEIGHT    = 3'd1,
        CFG_CHANNEL_COUNT = 3'd2,
        CFG_SCALE_X       = 3'd3,
        CFG_SCALE_Y       = 3'd4
    } cfg_idx_t;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

endpackage

>>> hw/rtl/bir_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module bir_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hw/rtl/bilinear_image_resampler_core.sv
// Bilinear image resampler. Loads write source bytes into the frame store;
// sample requests map (col,row) through the Q8.16 scales to a source point,
// fetch its four neighbors and blend them, answering one byte per request.
// Rate: one request (load or sample) per cycle while the skid is empty; the
// pipe halts while it is full. A sample's result passes the request, product,
// neighbor, read and blend registers, then the output register. The rate is
// set by the frame store: it is held as four copies, each with one read port,
// all written by every load, so all four neighbors are read in the same cycle.
// Loads give no result. A two-entry output (output register plus skid) lets the
// pipe keep taking requests while one result waits. No clearing pass after
// reset.
// Depends on bir_pkg and bir_ram.
module bilinear_image_resampler_core #(
    parameter int MAX_WIDTH    = bir_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT   = bir_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_CHANNELS = bir_pkg::DEF_MAX_CHANNELS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            kind,
    input  logic [bir_pkg::STORE_AW-1:0]    load_address,
    input  logic [bir_pkg::DATA_W-1:0]      load_value,
    input  logic [bir_pkg::COORD_W-1:0]     out_col,
    input  logic [bir_pkg::COORD_W-1:0]     out_row,
    input  logic [bir_pkg::CH_W-1:0]        out_channel,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bir_pkg::DATA_W-1:0]      sample_value,
    output logic                            out_of_range,
    // configuration
    input  logic                            cfg_we,
    input  logic [bir_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bir_pkg::CFG_W-1:0]       cfg_data
);

    import bir_pkg::*;

    localparam int WW   = $clog2(MAX_WIDTH + 1);     // effective width
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int XW   = $clog2(MAX_WIDTH);         // column index
    localparam int YW   = $clog2(MAX_HEIGHT);
    localparam int PW   = 2 * COORD_W + SCALE_W - COORD_W; // product width
    localparam int IW   = PW - FRAC_W;               // integer part of position
    localparam int RW   = YW + WW;                   // row base y*w
    localparam int PXW  = RW + 1;                    // pixel index
    localparam int AFW  = PXW + CHANS_W;             // full byte address
    localparam int NB   = 4;                         // neighbor copies

    // ---------------- configuration registers ----------------
    logic [SIZE_W-1:0]  src_width_reg, src_height_reg;
    logic [CHANS_W-1:0] channel_count_reg;
    logic [SCALE_W-1:0] scale_x_reg, scale_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg     <= RST_SRC_WIDTH;
            src_height_reg    <= RST_SRC_HEIGHT;
            channel_count_reg <= RST_CHANNELS;
            scale_x_reg       <= RST_SCALE;
            scale_y_reg       <= RST_SCALE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SRC_WIDTH:     src_width_reg     <= cfg_data[SIZE_W-1:0];
                CFG_SRC_HEIGHT:    src_height_reg    <= cfg_data[SIZE_W-1:0];
                CFG_CHANNEL_COUNT: channel_count_reg <= cfg_data[CHANS_W-1:0];
                CFG_SCALE_X:       scale_x_reg       <= cfg_data[SCALE_W-1:0];
                CFG_SCALE_Y:       scale_y_reg       <= cfg_data[SCALE_W-1:0];
                default:           ;
            endcase
        end
    end

    // effective sizes: saturate to the build maxima, zero channels acts as one
    logic [WW-1:0]      w_eff;
    logic [HW-1:0]      h_eff;
    logic [CHANS_W-1:0] c_eff;

    always_comb
    begin
        w_eff = WW'((32'(src_width_reg) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH)
                                                           : 32'(src_width_reg));
        h_eff = HW'((32'(src_height_reg) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT)
                                                             : 32'(src_height_reg));
        if (channel_count_reg == '0)
        begin
            c_eff = CHANS_W'(1);
        end
        else if (32'(channel_count_reg) > 32'(MAX_CHANNELS))
        begin
            c_eff = CHANS_W'(MAX_CHANNELS);
        end
        else
        begin
            c_eff = channel_count_reg;
        end
    end

    // ---------------- flow control ----------------
    // The whole pipe moves together; it halts only when the skid is full.
    logic skid_valid_reg;
    logic adv;

    assign adv      = !skid_valid_reg;
    assign in_ready = adv;

    // ---------------- stage 1: request register ----------------
    logic                s1_valid_reg;
    logic                s1_kind_reg;
    logic [STORE_AW-1:0] s1_laddr_reg;
    logic [DATA_W-1:0]   s1_lval_reg;
    logic [COORD_W-1:0]  s1_col_reg, s1_row_reg;
    logic [CH_W-1:0]     s1_ch_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_kind_reg  <= kind;
            s1_laddr_reg <= load_address;
            s1_lval_reg  <= load_value;
            s1_col_reg   <= out_col;
            s1_row_reg   <= out_row;
            s1_ch_reg    <= out_channel;
        end
    end

    // ---------------- stage 2: source position products ----------------
    logic                s2_valid_reg;
    logic                s2_kind_reg;
    logic [STORE_AW-1:0] s2_laddr_reg;
    logic [DATA_W-1:0]   s2_lval_reg;
    logic [CH_W-1:0]     s2_ch_reg;
    logic [PW-1:0]       s2_px_reg, s2_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_kind_reg  <= s1_kind_reg;
            s2_laddr_reg <= s1_laddr_reg;
            s2_lval_reg  <= s1_lval_reg;
            s2_ch_reg    <= s1_ch_reg;
            s2_px_reg    <= PW'(scale_x_reg) * PW'(s1_col_reg);
            s2_py_reg    <= PW'(scale_y_reg) * PW'(s1_row_reg);
        end
    end

    // ---------------- stage 3: neighbors, range check, row bases ----------------
    logic [IW-1:0]     x0_full, y0_full;
    logic [XW-1:0]     x0_idx, x1_idx;
    logic [YW-1:0]     y0_idx, y1_idx;
    logic              oor_now;

    always_comb
    begin
        x0_full = s2_px_reg[PW-1:FRAC_W];
        y0_full = s2_py_reg[PW-1:FRAC_W];
        x0_idx  = x0_full[XW-1:0];
        y0_idx  = y0_full[YW-1:0];
        oor_now = (w_eff == '0) || (h_eff == '0)
                  || (32'(x0_full) >= 32'(w_eff))
                  || (32'(y0_full) >= 32'(h_eff))
                  || (CHANS_W'(s2_ch_reg) >= c_eff);
        // next neighbor clamps to the last column / row
        x1_idx = (32'(x0_idx) + 32'd1 >= 32'(w_eff)) ? x0_idx : x0_idx + XW'(1);
        y1_idx = (32'(y0_idx) + 32'd1 >= 32'(h_eff)) ? y0_idx : y0_idx + YW'(1);
    end

    logic                s3_valid_reg;
    logic                s3_kind_reg;
    logic [STORE_AW-1:0] s3_laddr_reg;
    logic [DATA_W-1:0]   s3_lval_reg;
    logic [CH_W-1:0]     s3_ch_reg;
    logic [XW-1:0]       s3_x0_reg, s3_x1_reg;
    logic [RW-1:0]       s3_yw0_reg, s3_yw1_reg;
    logic [FRAC_W-1:0]   s3_u_reg, s3_v_reg;
    logic                s3_oor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_kind_reg  <= s2_kind_reg;
            s3_laddr_reg <= s2_laddr_reg;
            s3_lval_reg  <= s2_lval_reg;
            s3_ch_reg    <= s2_ch_reg;
            s3_x0_reg    <= x0_idx;
            s3_x1_reg    <= x1_idx;
            s3_yw0_reg   <= RW'(y0_idx) * RW'(w_eff);
            s3_yw1_reg   <= RW'(y1_idx) * RW'(w_eff);
            s3_u_reg     <= s2_px_reg[FRAC_W-1:0];
            s3_v_reg     <= s2_py_reg[FRAC_W-1:0];
            s3_oor_reg   <= oor_now;
        end
    end

    // ---------------- frame store: four copies, one per neighbor ----------------
    // neighbor order: (x0,y0) (x1,y0) (x0,y1) (x1,y1)
    logic [STORE_AW-1:0] nb_addr [NB];
    logic [DATA_W-1:0]   nb_data [NB];
    logic [XW-1:0]       nb_x    [NB];
    logic [RW-1:0]       nb_row  [NB];
    logic                ram_we, ram_re;

    assign ram_we = adv && s3_valid_reg && (s3_kind_reg == KIND_LOAD);
    assign ram_re = adv && s3_valid_reg && (s3_kind_reg == KIND_SAMPLE);

    always_comb
    begin
        nb_x[0]   = s3_x0_reg;  nb_row[0] = s3_yw0_reg;
        nb_x[1]   = s3_x1_reg;  nb_row[1] = s3_yw0_reg;
        nb_x[2]   = s3_x0_reg;  nb_row[2] = s3_yw1_reg;
        nb_x[3]   = s3_x1_reg;  nb_row[3] = s3_yw1_reg;
    end

    for (genvar g = 0; g < NB; g++)
    begin : g_bank
        logic [PXW-1:0]          pix;
        logic [AFW-1:0]          addr_full;
        logic [AFW+STORE_AW-1:0] addr_ext;

        assign pix       = PXW'(nb_row[g]) + PXW'(nb_x[g]);
        assign addr_full = AFW'(c_eff) * AFW'(pix) + AFW'(s3_ch_reg);
        assign addr_ext  = {{STORE_AW{1'b0}}, addr_full};
        assign nb_addr[g] = addr_ext[STORE_AW-1:0];    // wraps modulo store depth

        bir_ram #(
            .WIDTH (DATA_W),
            .DEPTH (2 ** STORE_AW)
        ) u_store (
            .clk   (clk),
            .we    (ram_we),
            .waddr (s3_laddr_reg),
            .wdata (s3_lval_reg),
            .re    (ram_re),
            .raddr (nb_addr[g]),
            .rdata (nb_data[g])
        );
    end

    // ---------------- stage 4: read data lands (RAM register) ----------------
    logic              s4_valid_reg;
    logic [FRAC_W-1:0] s4_u_reg, s4_v_reg;
    logic              s4_oor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_valid_reg <= s3_valid_reg && (s3_kind_reg == KIND_SAMPLE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_u_reg   <= s3_u_reg;
            s4_v_reg   <= s3_v_reg;
            s4_oor_reg <= s3_oor_reg;
        end
    end

    // ---------------- stage 5: horizontal blends (Q8.16) ----------------
    logic [FRAC_W:0]   wu0, wu1;
    logic [FRAC_W+DATA_W:0] h_top, h_bot;

    always_comb
    begin
        wu1   = {1'b0, s4_u_reg};
        wu0   = FRAC_ONE - wu1;
        h_top = (FRAC_W+DATA_W+1)'(wu0) * (FRAC_W+DATA_W+1)'(nb_data[0])
              + (FRAC_W+DATA_W+1)'(wu1) * (FRAC_W+DATA_W+1)'(nb_data[1]);
        h_bot = (FRAC_W+DATA_W+1)'(wu0) * (FRAC_W+DATA_W+1)'(nb_data[2])
              + (FRAC_W+DATA_W+1)'(wu1) * (FRAC_W+DATA_W+1)'(nb_data[3]);
    end

    logic                     s5_valid_reg;
    logic [FRAC_W+DATA_W-1:0] s5_i1_reg, s5_i2_reg;
    logic [FRAC_W-1:0]        s5_v_reg;
    logic                     s5_oor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_i1_reg  <= h_top[FRAC_W+DATA_W-1:0];
            s5_i2_reg  <= h_bot[FRAC_W+DATA_W-1:0];
            s5_v_reg   <= s4_v_reg;
            s5_oor_reg <= s4_oor_reg;
        end
    end

    // ---------------- stage 6: vertical blend (Q8.32), truncate ----------------
    localparam int VW = 2 * FRAC_W + DATA_W + 1;
    logic [FRAC_W:0]   wv0, wv1;
    logic [VW-1:0]     v_acc;
    logic              arrive;
    logic [DATA_W-1:0] res_value;

    always_comb
    begin
        wv1   = {1'b0, s5_v_reg};
        wv0   = FRAC_ONE - wv1;
        v_acc = VW'(wv0) * VW'(s5_i1_reg) + VW'(wv1) * VW'(s5_i2_reg);
        res_value = s5_oor_reg ? '0 : v_acc[2*FRAC_W+DATA_W-1:2*FRAC_W];
        arrive    = adv && s5_valid_reg;
    end

    // ---------------- output register and skid ----------------
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg, skid_value_reg;
    logic              out_oor_reg, skid_oor_reg;
    logic              take;

    assign take = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= arrive;
            end
        end
        else if (arrive)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_value_reg <= skid_value_reg;
                out_oor_reg   <= skid_oor_reg;
            end
            else
            begin
                out_value_reg <= res_value;
                out_oor_reg   <= s5_oor_reg;
            end
        end
        else if (arrive)
        begin
            skid_value_reg <= res_value;
            skid_oor_reg   <= s5_oor_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_value = out_value_reg;
    assign out_of_range = out_oor_reg;

    // ---------------- assertions ----------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output register is empty");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !out_ready |=> skid_valid_reg && $stable(skid_value_reg))
        else $error("skid result lost or changed while stalled");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_oor_reg |-> out_value_reg == '0)
        else $error("out-of-range result carries nonzero value");

    a_store_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("frame store written and read by one request");

endmodule
